### design/cvkt_pkg.sv
// ----------------------------------------------------------------------------
// cvkt_pkg
// Shared types, micro-op codes, register indexes and fixed-point helpers for
// the constant-velocity Kalman tracker.
// ----------------------------------------------------------------------------
package cvkt_pkg;

    localparam int PW = 65;   // signed 33x32 product
    localparam int SW = 67;   // working width for sums before saturation

    typedef logic [3:0] op_t;

    localparam op_t OP_DT   = 4'd0;   // dt = tick_period * elapsed
    localparam op_t OP_P1   = 4'd1;   // predicted position
    localparam op_t OP_M    = 4'd2;   // pv + dt*vv
    localparam op_t OP_T    = 4'd3;   // pp + dt*pv + q_pp partial
    localparam op_t OP_PP1  = 4'd4;   // predicted pp, pv, vv, innovation
    localparam op_t OP_KP   = 4'd5;
    localparam op_t OP_KV   = 4'd6;
    localparam op_t OP_EP   = 4'd7;
    localparam op_t OP_EV   = 4'd8;
    localparam op_t OP_CPP  = 4'd9;
    localparam op_t OP_CPV  = 4'd10;
    localparam op_t OP_CVV  = 4'd11;
    localparam op_t OP_TICK = 4'd12;  // advance published prediction

    localparam logic OPC_TICK = 1'b0;
    localparam logic OPC_MEAS = 1'b1;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_TICK_PERIOD  = 3'd0;
    localparam reg_idx_t REG_PREDICT_STEP = 3'd1;
    localparam reg_idx_t REG_NOISE_PP     = 3'd2;
    localparam reg_idx_t REG_NOISE_PV     = 3'd3;
    localparam reg_idx_t REG_NOISE_VV     = 3'd4;
    localparam reg_idx_t REG_MEAS_NOISE_X = 3'd5;
    localparam reg_idx_t REG_MEAS_NOISE_Y = 3'd6;
    localparam reg_idx_t REG_MEAS_NOISE_Z = 3'd7;

    localparam logic [31:0] RST_TICK_PERIOD  = 32'd3277;
    localparam logic [31:0] RST_PREDICT_STEP = 32'd655;
    localparam logic [30:0] RST_NOISE_PP     = 31'd2946;
    localparam logic [30:0] RST_NOISE_PV     = 31'd589091;
    localparam logic [30:0] RST_NOISE_VV     = 31'd117817999;
    localparam logic [30:0] RST_MEAS_NOISE_X = 31'd8388608;
    localparam logic [30:0] RST_MEAS_NOISE_Y = 31'd9227469;
    localparam logic [30:0] RST_MEAS_NOISE_Z = 31'd7549747;

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

    typedef struct packed {
        logic       accept;
        logic       mul;
        logic       wb;
        op_t        op;
        logic [1:0] axis;
        logic       div_start;
        logic       set_fresh;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic logic signed [SW-1:0] sx32(input logic signed [31:0] v);
        return $signed({{(SW-32){v[31]}}, v});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = sx32(32'sh7FFF_FFFF);
        lo = sx32(32'sh8000_0000);
        if (x > hi)
            return 32'sh7FFF_FFFF;
        else if (x < lo)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

endpackage

### design/cvkt_recip.sv
// ----------------------------------------------------------------------------
// cvkt_recip
// Restoring divider for floor(2^48 / s), one quotient bit per cycle,
// saturated to 2^31-1. A non-positive divisor gives zero.
// ----------------------------------------------------------------------------
module cvkt_recip
    import cvkt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        pos,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [30:0] quot
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [48:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        trial     = {rem_reg[31:0], (cnt_reg == 6'd48)};
        if (start) begin
            rem_next = '0;
            q_next   = '0;
            d_next   = divisor;
            cnt_next = 6'd48;
            if (pos)
                busy_next = 1'b1;
            else
                done_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                rem_next = trial - {1'b0, d_reg};
                q_next   = {q_reg[47:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[47:0], 1'b0};
            end
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign quot = (|q_reg[48:31]) ? 31'h7FFF_FFFF : q_reg[30:0];

endmodule

### design/cvkt_datapath.sv
// ----------------------------------------------------------------------------
// cvkt_datapath
// Filter state, configuration registers, shared 33x32 multiplier with
// saturating write-back, reciprocal unit and result register.
// ----------------------------------------------------------------------------
module cvkt_datapath
    import cvkt_pkg::*;
#(
    parameter int AXES       = 3,
    parameter int WRAP_LIMIT = 30000
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    output sts_t         sts,
    input  logic         s_opcode,
    input  logic [191:0] s_box,
    input  logic         cfg_wr,
    input  reg_idx_t     cfg_index,
    input  logic [31:0]  cfg_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata
);

    localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

    // configuration
    logic [31:0] tick_period_reg, predict_step_reg;
    logic [30:0] npp_reg, npv_reg, nvv_reg, mnx_reg, mny_reg, mnz_reg;

    // counters
    logic [14:0] tick_reg, last_reg, tick_inc;
    logic        fresh_reg;

    // filter state
    logic signed [31:0] est_pos_reg [AXES];
    logic signed [31:0] est_vel_reg [AXES];
    logic signed [31:0] cov_pp_reg  [AXES];
    logic signed [31:0] cov_pv_reg  [AXES];
    logic signed [31:0] cov_vv_reg  [AXES];
    logic signed [31:0] pred_pos_reg[AXES];
    logic signed [31:0] pred_vel_reg[AXES];
    logic signed [31:0] box_size_reg[AXES];

    // scratch
    logic [191:0]       box_reg;
    logic [31:0]        dt_reg;
    logic signed [31:0] p1_reg, m_reg, pp1_reg, pv1_reg, vv1_reg;
    logic signed [31:0] kp_reg, kv_reg, y_reg, zc_reg;
    logic signed [SW-1:0] acc_reg;
    logic signed [PW-1:0] prod_reg;

    logic         out_valid_reg;
    logic [191:0] out_reg, out_next;

    logic [AXW-1:0]     ax;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [SW-1:0] pw, ps16, ps24, s_w;
    logic signed [32:0] box_sum;
    logic signed [31:0] lo, hi;
    logic [30:0]        mn_sel, recip;
    logic               div_done, s_pos;

    assign ax   = cmd.axis[AXW-1:0];
    assign lo   = box_reg[31:0];
    assign hi   = box_reg[63:32];
    assign pw   = $signed({{(SW-PW){prod_reg[PW-1]}}, prod_reg});
    assign ps16 = pw >>> 16;
    assign ps24 = pw >>> 24;
    assign box_sum  = {lo[31], lo} + {hi[31], hi};
    assign tick_inc = tick_reg + 15'd1;

    always_comb begin
        case (cmd.axis)
            2'd0:    mn_sel = mnx_reg;
            2'd1:    mn_sel = mny_reg;
            default: mn_sel = mnz_reg;
        endcase
    end

    assign s_w   = sx32(pp1_reg) + $signed({{(SW-31){1'b0}}, mn_sel});
    assign s_pos = !s_w[SW-1] && (s_w != '0);

    cvkt_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .pos     (s_pos),
        .divisor (s_w[31:0]),
        .done    (div_done),
        .quot    (recip)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_DT: begin
                mul_a = {1'b0, tick_period_reg};
                mul_b = {17'd0, tick_reg - last_reg};
            end
            OP_P1:   begin mul_a = {1'b0, dt_reg}; mul_b = est_vel_reg[ax]; end
            OP_M:    begin mul_a = {1'b0, dt_reg}; mul_b = cov_vv_reg[ax];  end
            OP_T:    begin mul_a = {1'b0, dt_reg}; mul_b = cov_pv_reg[ax];  end
            OP_PP1:  begin mul_a = {1'b0, dt_reg}; mul_b = m_reg;           end
            OP_KP:   begin mul_a = {pp1_reg[31], pp1_reg}; mul_b = {1'b0, recip}; end
            OP_KV:   begin mul_a = {pv1_reg[31], pv1_reg}; mul_b = {1'b0, recip}; end
            OP_EP:   begin mul_a = {kp_reg[31], kp_reg}; mul_b = y_reg;   end
            OP_EV:   begin mul_a = {kv_reg[31], kv_reg}; mul_b = y_reg;   end
            OP_CPP:  begin mul_a = {kp_reg[31], kp_reg}; mul_b = pp1_reg; end
            OP_CPV:  begin mul_a = {kp_reg[31], kp_reg}; mul_b = pv1_reg; end
            OP_CVV:  begin mul_a = {kv_reg[31], kv_reg}; mul_b = pv1_reg; end
            OP_TICK: begin
                mul_a = {1'b0, predict_step_reg};
                mul_b = pred_vel_reg[ax];
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        out_next = '0;
        for (int a = 0; a < AXES; a++) begin
            out_next[32*a +: 32]     = pred_pos_reg[a];
            out_next[32*(a+3) +: 32] = box_size_reg[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg  <= RST_TICK_PERIOD;
            predict_step_reg <= RST_PREDICT_STEP;
            npp_reg <= RST_NOISE_PP;
            npv_reg <= RST_NOISE_PV;
            nvv_reg <= RST_NOISE_VV;
            mnx_reg <= RST_MEAS_NOISE_X;
            mny_reg <= RST_MEAS_NOISE_Y;
            mnz_reg <= RST_MEAS_NOISE_Z;
            tick_reg  <= '0;
            last_reg  <= '0;
            fresh_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                est_pos_reg[a]  <= ONE_Q16;
                est_vel_reg[a]  <= '0;
                cov_pp_reg[a]   <= ONE_Q24;
                cov_pv_reg[a]   <= '0;
                cov_vv_reg[a]   <= ONE_Q24;
                pred_pos_reg[a] <= ONE_Q16;
                pred_vel_reg[a] <= '0;
                box_size_reg[a] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (cfg_index)
                    REG_TICK_PERIOD:  tick_period_reg  <= cfg_data;
                    REG_PREDICT_STEP: predict_step_reg <= cfg_data;
                    REG_NOISE_PP:     npp_reg <= cfg_data[30:0];
                    REG_NOISE_PV:     npv_reg <= cfg_data[30:0];
                    REG_NOISE_VV:     nvv_reg <= cfg_data[30:0];
                    REG_MEAS_NOISE_X: mnx_reg <= cfg_data[30:0];
                    REG_MEAS_NOISE_Y: mny_reg <= cfg_data[30:0];
                    REG_MEAS_NOISE_Z: mnz_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (cmd.accept && s_opcode == OPC_TICK) begin
                if (tick_inc > 15'(WRAP_LIMIT)) begin
                    tick_reg <= tick_inc - last_reg;
                    last_reg <= '0;
                end else begin
                    tick_reg <= tick_inc;
                end
            end

            if (cmd.wb) begin
                case (cmd.op)
                    OP_DT:  last_reg <= tick_reg;
                    OP_P1:  box_size_reg[ax] <= sat32(sx32(hi) - sx32(lo));
                    OP_EP:  est_pos_reg[ax] <= sat32(sx32(p1_reg) + ps24);
                    OP_EV:  est_vel_reg[ax] <= sat32(sx32(est_vel_reg[ax]) + ps24);
                    OP_CPP: cov_pp_reg[ax]  <= sat32(sx32(pp1_reg) - ps24);
                    OP_CPV: cov_pv_reg[ax]  <= sat32(sx32(pv1_reg) - ps24);
                    OP_CVV: cov_vv_reg[ax]  <= sat32(sx32(vv1_reg) - ps24);
                    OP_TICK: begin
                        if (fresh_reg) begin
                            pred_pos_reg[ax] <= est_pos_reg[ax];
                            pred_vel_reg[ax] <= est_vel_reg[ax];
                        end else begin
                            pred_pos_reg[ax] <= sat32(sx32(pred_pos_reg[ax]) + ps16);
                        end
                    end
                    default: ;
                endcase
            end

            if (cmd.set_fresh)
                fresh_reg <= 1'b1;
            if (cmd.load_out)
                fresh_reg <= 1'b0;

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end

        // scratch values, no reset needed
        if (cmd.accept)
            box_reg <= s_box;
        if (cmd.mul)
            prod_reg <= mul_a * mul_b;
        if (cmd.load_out)
            out_reg <= out_next;
        if (cmd.wb) begin
            case (cmd.op)
                OP_DT:  dt_reg <= (|prod_reg[PW-1:32]) ? 32'hFFFF_FFFF : prod_reg[31:0];
                OP_P1: begin
                    p1_reg  <= sat32(sx32(est_pos_reg[ax]) + ps16);
                    zc_reg  <= box_sum[32:1];
                    box_reg <= {64'd0, box_reg[191:64]};
                end
                OP_M:   m_reg <= sat32(sx32(cov_pv_reg[ax]) + ps16);
                OP_T:   acc_reg <= sx32(cov_pp_reg[ax]) + ps16
                                 + $signed({{(SW-31){1'b0}}, npp_reg});
                OP_PP1: begin
                    pp1_reg <= sat32(acc_reg + ps16);
                    pv1_reg <= sat32(sx32(m_reg) + $signed({{(SW-31){1'b0}}, npv_reg}));
                    vv1_reg <= sat32(sx32(cov_vv_reg[ax])
                                     + $signed({{(SW-31){1'b0}}, nvv_reg}));
                    y_reg   <= sat32(sx32(zc_reg) - sx32(p1_reg));
                end
                OP_KP:  kp_reg <= sat32(ps24);
                OP_KV:  kv_reg <= sat32(ps24);
                default: ;
            endcase
        end
    end

    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_reg;

endmodule

### design/cvkt_ctrl.sv
// ----------------------------------------------------------------------------
// cvkt_ctrl
// Sequencer: walks the per-axis micro-op list for a measure request and the
// prediction update for a tick request, handing off the result after a tick.
// ----------------------------------------------------------------------------
module cvkt_ctrl
    import cvkt_pkg::*;
#(
    parameter int AXES = 3
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic s_opcode,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_WB   = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DIVW = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    op_t        op_reg, op_next;
    logic [1:0] axis_reg, axis_next;
    logic       last_axis;

    assign last_axis = (axis_reg == 2'(AXES - 1));
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.op     = op_reg;
        cmd.axis   = axis_reg;
        state_next = state_reg;
        op_next    = op_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    axis_next  = '0;
                    op_next    = (s_opcode == OPC_MEAS) ? OP_DT : OP_TICK;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                cmd.wb     = 1'b1;
                state_next = ST_MUL;
                case (op_reg)
                    OP_DT:  op_next = OP_P1;
                    OP_P1:  op_next = OP_M;
                    OP_M:   op_next = OP_T;
                    OP_T:   op_next = OP_PP1;
                    OP_PP1: state_next = ST_DIV;
                    OP_KP:  op_next = OP_KV;
                    OP_KV:  op_next = OP_EP;
                    OP_EP:  op_next = OP_EV;
                    OP_EV:  op_next = OP_CPP;
                    OP_CPP: op_next = OP_CPV;
                    OP_CPV: op_next = OP_CVV;
                    OP_CVV: begin
                        if (last_axis) begin
                            cmd.set_fresh = 1'b1;
                            state_next    = ST_IDLE;
                        end else begin
                            axis_next = axis_reg + 2'd1;
                            op_next   = OP_P1;
                        end
                    end
                    OP_TICK: begin
                        if (last_axis)
                            state_next = ST_OUT;
                        else
                            axis_next = axis_reg + 2'd1;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW: begin
                if (sts.div_done) begin
                    op_next    = OP_KP;
                    state_next = ST_MUL;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_DT;
            axis_reg  <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            axis_reg  <= axis_next;
        end
    end

    // write-back always follows a multiply cycle
    a_wb_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WB |-> $past(state_reg) == ST_MUL)
        else $error("write-back without multiply");

    // result register is only loaded when free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result overwritten");

    // one request at a time
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");

    // axis never leaves the configured range
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> axis_reg <= 2'(AXES - 1))
        else $error("axis out of range");

endmodule

### design/constant_velocity_kalman_tracker_3d_core.sv
// ----------------------------------------------------------------------------
// constant_velocity_kalman_tracker_3d_core
// Per-axis 2x2 constant-velocity Kalman filter tracking one 3D box.
// ----------------------------------------------------------------------------
// Sequence: a tick request runs a multiply and a write-back step per axis,
//   then loads the result for m_tvalid; a measure runs the per-axis micro-ops,
//   each a multiply and a write-back step, plus the 49-bit serial reciprocal.
// Throughput: one request at a time; a measure may run while a result waits.
// Reset: aresetn synchronous, active low; filter state and registers return
//   to their documented reset values.
// ----------------------------------------------------------------------------
module constant_velocity_kalman_tracker_3d_core
    import cvkt_pkg::*;
#(
    parameter int AXES       = 3,
    parameter int WRAP_LIMIT = 30000
) (
    input  logic         aclk,
    input  logic         aresetn,

    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // box_x_min, box_x_max, box_y_min, box_y_max, box_z_min, box_z_max
    input  logic [191:0] s_tdata,
    // opcode: 0 tick, 1 measure
    input  logic [0:0]   s_tuser,

    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // pred_x, pred_y, pred_z, size_x, size_y, size_z
    output logic [191:0] m_tdata,

    // register write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // registers always writable; user must write only while idle, unchecked
    assign cfg_ready = 1'b1;

    cvkt_ctrl #(
        .AXES (AXES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_opcode (s_tuser[0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    cvkt_datapath #(
        .AXES       (AXES),
        .WRAP_LIMIT (WRAP_LIMIT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_opcode  (s_tuser[0]),
        .s_box     (s_tdata),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
